// File: sv/flm_pkg.sv
// shared types, constants and helpers of the fixed-string line matcher
package flm_pkg;

  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned OFF_W     = 12;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned ADDR_W    = 6;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA   = 8'h20;

  typedef enum logic [2:0] {
    REG_PAT_LO    = 3'd0,
    REG_PAT_HI    = 3'd1,
    REG_PAT_LEN   = 3'd2,
    REG_CASE_FOLD = 3'd3,
    REG_INVERT    = 3'd4
  } flm_reg_e;

  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [LEN_W-1:0]          length;
    logic                      case_fold;
    logic                      invert_match;
  } flm_cfg_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic upper;
    upper = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
    fold_byte = (en && upper) ? (c + CASE_DELTA) : c;
  endfunction

endpackage

// File: sv/flm_if.sv
// valid/ready channel interfaces for text bytes and line results
interface flm_in_if
  import flm_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_input;

  modport source (output valid, output byte_value, output end_of_input, input ready);
  modport sink (input valid, input byte_value, input end_of_input, output ready);
endinterface

interface flm_out_if
  import flm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             line_valid;
  logic [CNT_W-1:0] line_number;
  logic             line_selected;
  logic [OFF_W-1:0] match_offset;
  logic [CNT_W-1:0] selected_count;
  logic             any_selected;
  logic             stream_end;

  modport source (
    output valid, output line_valid, output line_number, output line_selected,
    output match_offset, output selected_count, output any_selected,
    output stream_end, input ready
  );
  modport sink (
    input valid, input line_valid, input line_number, input line_selected,
    input match_offset, input selected_count, input any_selected,
    input stream_end, output ready
  );
endinterface

// File: sv/fixed_string_line_matcher.sv
// top level of the fixed-string line matcher
//
// text bytes enter on in_i, one transaction per byte; end_of_input marks the
// end of the stream and ignores byte_value. a line closes at a newline byte
// (kept in the line) or once RECORD_LIMIT_BYTES bytes have been taken.
// each closing line, and each end-of-stream marker, gives one transaction on
// out_o with the line number, selection flag, first match offset, selected
// line count and the sticky any_selected flag; other bytes give nothing.
// the pattern, its length, case folding and invert are set over the APB
// port (64-bit registers at byte address 8*i); the user must write them
// only while the block is idle; the block does not enforce it. bytes
// pass from the input register through the combinational window compare
// into the line state and result registers, one byte per cycle unless
// in_i stalls. a stalled out_o holds its result; bytes that close no line
// still pass through, and in_i stalls only when a second result would be
// needed. reset clears the registers, line state, counters and both stages.
module fixed_string_line_matcher
  import flm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES  = 16,
  parameter int unsigned RECORD_LIMIT_BYTES = 4095
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  flm_in_if.sink            in_i,
  flm_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned HIST   = (MAX_PATTERN_BYTES < PAT_BYTES) ?
                                   MAX_PATTERN_BYTES : PAT_BYTES;
  localparam int unsigned HIST_D = (HIST > 1) ? HIST - 1 : 1;
  localparam int unsigned POS_W  = $clog2(RECORD_LIMIT_BYTES + 1);
  localparam int unsigned EXT_W  = (POS_W > OFF_W) ? POS_W : OFF_W;
  localparam logic [POS_W:0] LIMIT = (POS_W+1)'(RECORD_LIMIT_BYTES);

  flm_cfg_t cfg_q;

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;
  logic                 s1_eoi_q;

  logic [HIST_D-1:0][7:0] hist_q, hist_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 found_q, found_d;
  logic [POS_W-1:0]     off_q, off_d;
  logic [CNT_W-1:0]     line_cnt_q, line_cnt_d;
  logic [CNT_W-1:0]     sel_cnt_q, sel_cnt_d;
  logic                 any_q, any_d;

  logic                 res_valid_q, res_valid_d;
  logic                 res_line_valid_q, res_line_valid_d;
  logic                 res_selected_q, res_selected_d;
  logic [OFF_W-1:0]     res_offset_q, res_offset_d;
  logic                 res_end_q, res_end_d;

  logic                 m_hit;
  logic [POS_W-1:0]     m_off;
  logic [POS_W:0]       pos_p1;
  logic                 emit;
  logic                 adv;
  logic                 close_line;
  logic                 found_new;
  logic [POS_W-1:0]     off_new;
  logic                 selected;
  logic [EXT_W-1:0]     off_ext;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        REG_PAT_LO:    cfg_q.pattern[7:0]  <= pwdata;
        REG_PAT_HI:    cfg_q.pattern[15:8] <= pwdata;
        REG_PAT_LEN:   cfg_q.length        <= pwdata[LEN_W-1:0];
        REG_CASE_FOLD: cfg_q.case_fold     <= pwdata[0];
        REG_INVERT:    cfg_q.invert_match  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_PAT_LO:    prdata = cfg_q.pattern[7:0];
      REG_PAT_HI:    prdata = cfg_q.pattern[15:8];
      REG_PAT_LEN:   prdata = DATA_W'(cfg_q.length);
      REG_CASE_FOLD: prdata = DATA_W'(cfg_q.case_fold);
      REG_INVERT:    prdata = DATA_W'(cfg_q.invert_match);
      default:       prdata = '0;
    endcase
  end

  flm_match #(
    .HIST   (HIST),
    .HIST_D (HIST_D),
    .POS_W  (POS_W)
  ) u_match (
    .cfg_i    (cfg_q),
    .byte_i   (s1_byte_q),
    .hist_i   (hist_q),
    .pos_i    (pos_q),
    .hit_o    (m_hit),
    .offset_o (m_off)
  );

  // handshake
  assign pos_p1 = {1'b0, pos_q} + (POS_W+1)'(1);
  assign emit   = s1_eoi_q || (s1_byte_q == CHAR_NEWLINE) || (pos_p1 >= LIMIT);
  assign adv    = s1_valid_q && (!emit || !res_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;

  always_comb begin
    hist_d    = hist_q;
    pos_d     = pos_q;
    found_d   = found_q;
    off_d     = off_q;
    line_cnt_d = line_cnt_q;
    sel_cnt_d = sel_cnt_q;
    any_d     = any_q;
    res_valid_d      = res_valid_q && !out_o.ready;
    res_line_valid_d = res_line_valid_q;
    res_selected_d   = res_selected_q;
    res_offset_d     = res_offset_q;
    res_end_d        = res_end_q;
    close_line = 1'b0;

    if (s1_eoi_q) begin
      found_new = found_q;
      off_new   = off_q;
    end else begin
      found_new = found_q || m_hit;
      off_new   = found_q ? off_q : m_off;
    end
    selected = found_new ^ cfg_q.invert_match;
    off_ext  = EXT_W'(found_new ? off_new : '0);

    if (adv) begin
      if (s1_eoi_q) begin
        close_line = pos_q != '0;
      end else begin
        hist_d[0] = s1_byte_q;
        for (int unsigned j = 1; j < HIST_D; j++) begin
          hist_d[j] = hist_q[j-1];
        end
        pos_d      = POS_W'(pos_p1);
        found_d    = found_new;
        off_d      = off_new;
        close_line = emit;
      end

      if (close_line) begin
        pos_d   = '0;
        found_d = 1'b0;
        off_d   = '0;
        if (line_cnt_q != '1) begin
          line_cnt_d = line_cnt_q + CNT_W'(1);
        end
        if (selected) begin
          any_d = 1'b1;
          if (sel_cnt_q != '1) begin
            sel_cnt_d = sel_cnt_q + CNT_W'(1);
          end
        end
      end

      if (emit) begin
        res_valid_d      = 1'b1;
        res_line_valid_d = close_line;
        res_selected_d   = close_line && selected;
        res_offset_d     = close_line ? off_ext[OFF_W-1:0] : '0;
        res_end_d        = s1_eoi_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      off_q       <= '0;
      line_cnt_q  <= '0;
      sel_cnt_q   <= '0;
      any_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      pos_q       <= pos_d;
      found_q     <= found_d;
      off_q       <= off_d;
      line_cnt_q  <= line_cnt_d;
      sel_cnt_q   <= sel_cnt_d;
      any_q       <= any_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.byte_value;
      s1_eoi_q  <= in_i.end_of_input;
    end
    hist_q           <= hist_d;
    res_line_valid_q <= res_line_valid_d;
    res_selected_q   <= res_selected_d;
    res_offset_q     <= res_offset_d;
    res_end_q        <= res_end_d;
  end

  // result port
  assign out_o.valid          = res_valid_q;
  assign out_o.line_valid     = res_line_valid_q;
  assign out_o.line_number    = line_cnt_q;
  assign out_o.line_selected  = res_selected_q;
  assign out_o.match_offset   = res_offset_q;
  assign out_o.selected_count = sel_cnt_q;
  assign out_o.any_selected   = any_q;
  assign out_o.stream_end     = res_end_q;

`ifndef NO_ASSERTIONS
  a_pos_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (POS_W+1)'(pos_q) < LIMIT)
    else $error("line position reached the record limit");

  a_found_needs_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> pos_q != '0)
    else $error("match flagged in an empty line");

  a_sel_not_above_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_cnt_q <= line_cnt_q)
    else $error("selected count above line count");

  a_any_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q == (sel_cnt_q != '0))
    else $error("any_selected disagrees with selected count");

  a_empty_end_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_line_valid_q) |-> (res_end_q && !res_selected_q))
    else $error("result without a line is not an end marker");
`endif

endmodule

// File: sv/flm_match.sv
// window compare of the pattern against the bytes ending at the current byte
module flm_match
  import flm_pkg::*;
#(
  parameter int unsigned HIST   = 16,
  parameter int unsigned HIST_D = 15,
  parameter int unsigned POS_W  = 12
) (
  input  flm_cfg_t                 cfg_i,
  input  logic [7:0]               byte_i,
  input  logic [HIST_D-1:0][7:0]   hist_i,
  input  logic [POS_W-1:0]         pos_i,
  output logic                     hit_o,
  output logic [POS_W-1:0]         offset_o
);

  localparam logic [LEN_W-1:0] LEN_LIM = LEN_W'(HIST);

  logic [LEN_W-1:0]      len_eff;
  logic [HIST-1:0][7:0]  window;
  logic [HIST-1:0]       eq;
  logic [POS_W:0]        pos_p1;
  logic [POS_W:0]        len_ext;
  logic [IDX_W-1:0]      idx;
  logic                  reach;

  always_comb begin
    len_eff = (cfg_i.length > LEN_LIM) ? LEN_LIM : cfg_i.length;
    window[0] = byte_i;
    for (int unsigned j = 1; j < HIST; j++) begin
      window[j] = hist_i[j-1];
    end
    eq = '0;
    for (int unsigned j = 0; j < HIST; j++) begin
      idx = IDX_W'(len_eff - LEN_W'(j) - LEN_W'(1));
      if (LEN_W'(j) >= len_eff) begin
        eq[j] = 1'b1;
      end else begin
        eq[j] = fold_byte(cfg_i.pattern[idx], cfg_i.case_fold) ==
                fold_byte(window[j], cfg_i.case_fold);
      end
    end
    pos_p1  = {1'b0, pos_i} + (POS_W+1)'(1);
    len_ext = (POS_W+1)'(len_eff);
    reach   = pos_p1 >= len_ext;
    if (len_eff == '0) begin
      hit_o    = 1'b1;
      offset_o = '0;
    end else begin
      hit_o    = reach && (&eq);
      offset_o = POS_W'(pos_p1 - len_ext);
    end
  end

endmodule
